/* rtl/max_priority_queue_heap_defines.svh */
// ----------------------------------------------------------------------------
// max_priority_queue_heap_defines.svh
// assertion macros used by the priority queue top module
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_HEAP_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_HEAP_DEFINES_SVH

`ifndef ASSERT_OFF

// clocked check, switched off while reset is held
`define MPQH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// clocked check over a cycle boundary, switched off while reset is held
`define MPQH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`else

`define MPQH_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPQH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

/* rtl/mpqh_pkg.sv */
// ----------------------------------------------------------------------------
// mpqh_pkg
// types, constants and the ordering function of the priority queue
// ----------------------------------------------------------------------------
package mpqh_pkg;

    // number of entries the queue can hold
    localparam int CAPACITY = 32;
    // width of the internal fill counter, able to hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;

    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  tag;
    } t_entry;

    // operation broadcast to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry ent;
    } t_cmd;

    // what a cell shows to its neighbours
    typedef struct packed {
        t_entry ent;
        logic   vld;
        logic   beat;
    } t_link;

    // true when entry a must sit above entry b
    function automatic logic beats(t_entry a, t_entry b);
        logic res;
        if (a.key != b.key) begin
            res = (a.key > b.key);
        end else begin
            res = (a.tag < b.tag);
        end
        return res;
    endfunction

endpackage

/* rtl/max_priority_queue_heap.sv */
// ----------------------------------------------------------------------------
// max_priority_queue_heap
// bounded max priority queue built as a sorted chain of cells
// ----------------------------------------------------------------------------
// Input channel: i_valid, i_req_type, i_entry_key, i_entry_tag, with o_stall
// back. A word is taken at a clock edge where i_valid is high and o_stall low.
// A push inserts the key and tag in order; a pop removes the top entry.
// Output channel: o_valid with the result fields, i_stall back. Each request
// gives one result word: top entry, empty flag, fill count and status.
// Every cell compares the incoming word with its own entry in parallel, so a
// request settles at the clock edge that takes it, and the result is written
// to the output register at that same edge. One request per cycle is
// sustained while the receiver does not stall.
// When the output register holds a word that is stalled, o_stall is raised
// and the held word does not change until it is taken.
// Reset (i_rst_n low, synchronous) empties the queue and drops any pending
// result. A push to a full queue or a pop from an empty one leaves the
// contents untouched and reports it in the status.
// ----------------------------------------------------------------------------
`include "max_priority_queue_heap_defines.svh"

module max_priority_queue_heap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_entry_key,
    input  logic [7:0]  i_entry_tag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_top_key,
    output logic [7:0]  o_top_tag,
    output logic        o_is_empty,
    output logic [5:0]  o_fill_count,
    output logic [1:0]  o_status
);

    localparam int CW = mpqh_pkg::CNT_W;

    mpqh_pkg::t_cmd   w_cmd;
    mpqh_pkg::t_link  w_lnk  [mpqh_pkg::CAPACITY];
    mpqh_pkg::t_entry w_nent [mpqh_pkg::CAPACITY];
    logic             w_nvld [mpqh_pkg::CAPACITY];
    mpqh_pkg::t_link  w_edge_prev;
    mpqh_pkg::t_link  w_edge_next;
    mpqh_pkg::t_entry w_top_nxt;
    logic             w_top_nxt_vld;
    logic [mpqh_pkg::CAPACITY-1:0] w_vld;

    logic             w_acc;
    logic             w_full;
    logic             w_empty;
    logic             w_ord01;
    logic             w_cnt_ok;
    logic             w_prefix_ok;
    logic             w_pop_refused;
    logic             w_refused_out;
    logic             w_flag_ok;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [1:0]       n_status;

    logic             r_out_vld;
    logic [15:0]      r_top_key;
    logic [7:0]       r_top_tag;
    logic             r_is_empty;
    logic [5:0]       r_fill_count;
    logic [1:0]       r_status;

    // handshake on the input side
    assign o_stall = r_out_vld && i_stall;
    assign w_acc   = i_valid && !o_stall;
    assign w_full  = (r_count == CW'(mpqh_pkg::CAPACITY));
    assign w_empty = (r_count == '0);

    // broadcast command to the chain
    always_comb begin
        w_cmd.push = w_acc && (i_req_type == mpqh_pkg::REQ_PUSH) && !w_full;
        w_cmd.pop  = w_acc && (i_req_type == mpqh_pkg::REQ_POP) && !w_empty;
        w_cmd.ent.key = i_entry_key;
        w_cmd.ent.tag = i_entry_tag;
    end

    // chain ends: nothing shifts in from above, an empty slot from below
    assign w_edge_prev = '0;
    assign w_edge_next = '0;

    // row of cells, slot 0 holds the top entry
    for (genvar gi = 0; gi < mpqh_pkg::CAPACITY; gi++) begin : g_cell
        mpqh_pkg::t_link  w_prev;
        mpqh_pkg::t_link  w_next;

        if (gi == 0) begin : g_first
            assign w_prev = w_edge_prev;
        end else begin : g_mid
            assign w_prev = w_lnk[gi-1];
        end

        if (gi == mpqh_pkg::CAPACITY - 1) begin : g_last
            assign w_next = w_edge_next;
        end else begin : g_body
            assign w_next = w_lnk[gi+1];
        end

        mpqh_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .o_link    (w_lnk[gi]),
            .o_nxt_ent (w_nent[gi]),
            .o_nxt_vld (w_nvld[gi])
        );

        assign w_vld[gi] = w_lnk[gi].vld;
    end

    // next contents of the top slot
    assign w_top_nxt     = w_nent[0];
    assign w_top_nxt_vld = w_nvld[0];

    // fill count and status of this request
    always_comb begin
        n_count  = r_count;
        n_status = mpqh_pkg::ST_OK;
        if (w_acc) begin
            if (i_req_type == mpqh_pkg::REQ_PUSH) begin
                if (w_full) begin
                    n_status = mpqh_pkg::ST_PUSH_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = mpqh_pkg::ST_POP_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
        end
    end

    // counter and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (!o_stall) begin
                r_out_vld <= w_acc;
            end
        end
        if (w_acc) begin
            r_fill_count <= 6'(n_count);
            r_status     <= n_status;
            if (n_count == '0 || !w_top_nxt_vld) begin
                r_top_key  <= '0;
                r_top_tag  <= '0;
                r_is_empty <= 1'b1;
            end else begin
                r_top_key  <= w_top_nxt.key;
                r_top_tag  <= w_top_nxt.tag;
                r_is_empty <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_top_key    = r_top_key;
    assign o_top_tag    = r_top_tag;
    assign o_is_empty   = r_is_empty;
    assign o_fill_count = r_fill_count;
    assign o_status     = r_status;

    // top two slots in order
    assign w_ord01 = !(w_lnk[1].vld && mpqh_pkg::beats(w_lnk[1].ent, w_lnk[0].ent));

    // terms for the checks
    assign w_cnt_ok      = ($countones(w_vld) == int'(r_count));
    assign w_prefix_ok   = !w_lnk[1].vld || w_lnk[0].vld;
    assign w_pop_refused = w_acc && (i_req_type == mpqh_pkg::REQ_POP) && w_empty;
    assign w_refused_out = o_valid && (o_status == mpqh_pkg::ST_POP_EMPTY);
    assign w_flag_ok     = !o_valid || (o_is_empty == (o_fill_count == 6'd0));

    // checks
    `MPQH_ASSERT(a_count_match, i_clk, i_rst_n, w_cnt_ok, "slot count differs from fill count")
    `MPQH_ASSERT(a_top_order, i_clk, i_rst_n, w_ord01, "second slot outranks top slot")
    `MPQH_ASSERT(a_prefix, i_clk, i_rst_n, w_prefix_ok, "hole at top of chain")
    `MPQH_ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n, w_pop_refused, w_refused_out, "empty pop")
    `MPQH_ASSERT(a_empty_flag, i_clk, i_rst_n, w_flag_ok, "empty flag disagrees with count")

endmodule

/* rtl/mpqh_cell.sv */
// ----------------------------------------------------------------------------
// mpqh_cell
// one slot of the sorted shift chain
// ----------------------------------------------------------------------------
module mpqh_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpqh_pkg::t_cmd   i_cmd,
    input  mpqh_pkg::t_link  i_prev,
    input  mpqh_pkg::t_link  i_next,
    output mpqh_pkg::t_link  o_link,
    output mpqh_pkg::t_entry o_nxt_ent,
    output logic             o_nxt_vld
);

    mpqh_pkg::t_entry r_ent;
    logic             r_vld;
    mpqh_pkg::t_entry n_ent;
    logic             n_vld;
    logic             w_beat;

    // new word belongs at or above this slot
    assign w_beat = !r_vld || mpqh_pkg::beats(i_cmd.ent, r_ent);

    // next slot contents: shift down on push, shift up on pop
    always_comb begin
        n_ent = r_ent;
        n_vld = r_vld;
        if (i_cmd.push) begin
            if (i_prev.beat) begin
                n_ent = i_prev.ent;
                n_vld = i_prev.vld;
            end else if (w_beat) begin
                n_ent = i_cmd.ent;
                n_vld = 1'b1;
            end
        end else if (i_cmd.pop) begin
            n_ent = i_next.ent;
            n_vld = i_next.vld;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_ent <= n_ent;
    end

    assign o_link.ent = r_ent;
    assign o_link.vld = r_vld;
    assign o_link.beat = w_beat;
    assign o_nxt_ent = n_ent;
    assign o_nxt_vld = n_vld;

endmodule

/* test/max_priority_queue_heap_tb.sv */
// ----------------------------------------------------------------------------
// max_priority_queue_heap_tb
// self-checking bench for the bounded max priority queue
// ----------------------------------------------------------------------------
// Push and pop words go in through the valid/stall input channel. A model of
// the queue, kept as a best-first list, works out the result word that each
// request should give. A monitor compares every result word field by field
// with the oldest one still due. Directed words cover key and tag extremes,
// ties on key and pops from an empty queue. A capacity pass fills the queue
// and then drains it. Random phases follow, with push or pop bias, bursty
// idling on both sides and a calm tail.
// ----------------------------------------------------------------------------
module max_priority_queue_heap_tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_WAIT = 16;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [15:0] top_key;
        logic [7:0]  top_tag;
        logic        is_empty;
        logic [5:0]  fill;
        logic [1:0]  status;
    } t_outcome;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_req_type   = mpqh_pkg::REQ_PUSH;
    logic [15:0] i_entry_key  = 16'h0000;
    logic [7:0]  i_entry_tag  = 8'h00;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_top_key;
    logic [7:0]  o_top_tag;
    logic        o_is_empty;
    logic [5:0]  o_fill_count;
    logic [1:0]  o_status;

    // queue contents as the model sees them, best entry first
    mpqh_pkg::t_entry held_q[$];
    // result words still owed by the block, oldest first
    t_outcome outcome_due_q[$];

    bit calm       = 1'b0;
    int stall_left = 0;
    int idle_run   = 0;
    int err_count  = 0;
    int n_push     = 0;
    int n_pop      = 0;
    int n_full     = 0;
    int n_empty    = 0;
    int n_checked  = 0;
    int deepest    = 0;

    max_priority_queue_heap dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_entry_key  (i_entry_key),
        .i_entry_tag  (i_entry_tag),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_top_key    (o_top_key),
        .o_top_tag    (o_top_tag),
        .o_is_empty   (o_is_empty),
        .o_fill_count (o_fill_count),
        .o_status     (o_status)
    );

    always #2 i_clk = ~i_clk;

    // higher key first, then lower tag
    function automatic bit ranks_above(mpqh_pkg::t_entry a, mpqh_pkg::t_entry b);
        return {a.key, ~a.tag} > {b.key, ~b.tag};
    endfunction

    // apply one request to the model queue and give the word it should produce
    function automatic t_outcome predict_queue_outcome(logic req, logic [15:0] key,
                                                       logic [7:0] tag);
        t_outcome         res;
        mpqh_pkg::t_entry ent;
        int               pos;
        res.status = mpqh_pkg::ST_OK;
        ent.key = key;
        ent.tag = tag;
        if (req == mpqh_pkg::REQ_PUSH) begin
            if (held_q.size() >= mpqh_pkg::CAPACITY) begin
                res.status = mpqh_pkg::ST_PUSH_FULL;
                n_full++;
            end else begin
                pos = 0;
                while (pos < held_q.size() && !ranks_above(ent, held_q[pos])) pos++;
                held_q.insert(pos, ent);
                n_push++;
            end
        end else begin
            if (held_q.size() == 0) begin
                res.status = mpqh_pkg::ST_POP_EMPTY;
                n_empty++;
            end else begin
                held_q.delete(0);
                n_pop++;
            end
        end
        if (held_q.size() == 0) begin
            res.top_key  = 16'h0000;
            res.top_tag  = 8'h00;
            res.is_empty = 1'b1;
        end else begin
            res.top_key  = held_q[0].key;
            res.top_tag  = held_q[0].tag;
            res.is_empty = 1'b0;
        end
        res.fill = 6'(held_q.size());
        if (held_q.size() > deepest) deepest = held_q.size();
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_REPORTS) begin
            $display("mismatch on %s: got %0h, want %0h (word %0d)",
                     what, got, want, n_checked);
        end
        err_count++;
    endtask

    // input acceptance, result checking and the no-progress watchdog
    always @(posedge i_clk) begin
        t_outcome want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                outcome_due_q.push_back(
                    predict_queue_outcome(i_req_type, i_entry_key, i_entry_tag));
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (outcome_due_q.size() == 0) begin
                    report_mismatch("result word with nothing due", 1, 0);
                end else begin
                    want = outcome_due_q[0];
                    outcome_due_q.delete(0);
                    if (o_top_key !== want.top_key)
                        report_mismatch("top_key", 32'(o_top_key), 32'(want.top_key));
                    if (o_top_tag !== want.top_tag)
                        report_mismatch("top_tag", 32'(o_top_tag), 32'(want.top_tag));
                    if (o_is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(o_is_empty), 32'(want.is_empty));
                    if (o_fill_count !== want.fill)
                        report_mismatch("fill_count", 32'(o_fill_count), 32'(want.fill));
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    n_checked++;
                end
            end
        end
        idle_run = moved ? 0 : idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("no word moved for %0d cycles, %0d results still due",
                     IDLE_LIMIT, outcome_due_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // offer one word, with an occasional gap first, and wait until it is taken
    task automatic send_word(input logic req, input logic [15:0] key,
                             input logic [7:0] tag);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_entry_key <= key;
        i_entry_tag <= tag;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // sender holds off until every result word has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outcome_due_q.size() != 0) @(posedge i_clk);
    endtask

    // keys lean on extremes and a tiny pool so that ties happen often
    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_tag();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    // extremes, ties on key and pops from an empty queue
    task automatic test_directed();
        send_word(mpqh_pkg::REQ_POP,  16'hFFFF, 8'hFF);
        send_word(mpqh_pkg::REQ_PUSH, 16'h0000, 8'h00);
        send_word(mpqh_pkg::REQ_PUSH, 16'hFFFF, 8'hFF);
        send_word(mpqh_pkg::REQ_PUSH, 16'hFFFF, 8'h00);
        send_word(mpqh_pkg::REQ_PUSH, 16'hFFFF, 8'h80);
        send_word(mpqh_pkg::REQ_PUSH, 16'h0000, 8'hFF);
        send_word(mpqh_pkg::REQ_PUSH, 16'h8000, 8'h01);
        send_word(mpqh_pkg::REQ_PUSH, 16'h7FFF, 8'hFE);
        repeat (7) send_word(mpqh_pkg::REQ_POP, 16'($urandom), 8'($urandom));
        send_word(mpqh_pkg::REQ_POP,  16'h0000, 8'h00);
        send_word(mpqh_pkg::REQ_PUSH, 16'h5AA5, 8'hA5);
        send_word(mpqh_pkg::REQ_POP,  16'h5AA5, 8'hA5);
    endtask

    // fill to capacity, push into a full queue, drain past empty
    task automatic test_capacity();
        repeat (mpqh_pkg::CAPACITY) send_word(mpqh_pkg::REQ_PUSH, pick_key(), pick_tag());
        repeat (2) send_word(mpqh_pkg::REQ_PUSH, pick_key(), pick_tag());
        repeat (mpqh_pkg::CAPACITY + 1)
            send_word(mpqh_pkg::REQ_POP, 16'($urandom), 8'($urandom));
    endtask

    task automatic run_phase(input int count, input int push_pct);
        repeat (count) begin
            if ($urandom_range(1, 100) <= push_pct) begin
                send_word(mpqh_pkg::REQ_PUSH, pick_key(), pick_tag());
            end else begin
                send_word(mpqh_pkg::REQ_POP, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // phases biased towards filling or draining, so the fill level wanders
    task automatic test_random_mix();
        run_phase(50, 80);
        run_phase(50, 20);
        run_phase(50, 90);
        wait_for_drain();
        run_phase(50, 60);
        run_phase(50, 40);
        run_phase(50, 10);
    endtask

    // last stretch without any idling on either side
    task automatic test_calm_tail();
        calm = 1'b1;
        run_phase(40, 85);
        run_phase(30, 30);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_for_drain();
        test_capacity();
        test_random_mix();
        test_calm_tail();

        wait_for_drain();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (outcome_due_q.size() != 0)
            report_mismatch("result words never delivered", outcome_due_q.size(), 0);

        $display("covered %0d pushes, %0d pops, %0d refused as full, %0d refused as empty",
                 n_push, n_pop, n_full, n_empty);
        $display("%0d result words checked, deepest fill %0d of %0d, %0d mismatches",
                 n_checked, deepest, mpqh_pkg::CAPACITY, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
